>>> hdl/tmsf_pkg.sv
package tmsf_pkg;

  // Field widths
  localparam int SAMPLE_W = 18;
  localparam int GAP_W    = 17;

  // Register reset value, 0.150 in 0.001 units
  localparam logic [GAP_W-1:0] GAP_RESET = 17'd150;

  // Window shape defaults
  localparam int WINDOW_DEF = 4;
  localparam int KEEP_DEF   = 2;

  // First sorted rank that enters the mean
  localparam int TRIM_LOW = 1;

  // Operation applied by every cell together
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FILL,
    OP_REPLACE,
    OP_SORT,
    OP_ROTATE
  } tmsf_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_SUM,
    S_DIV,
    S_DONE
  } tmsf_state_t;

  // Control broadcast to the cell row
  typedef struct packed {
    tmsf_op_t                     op;
    logic                         odd;
    logic signed [SAMPLE_W-1:0]   x;
  } tmsf_ctrl_t;

endpackage

>>> hdl/tmsf_cell.sv
module tmsf_cell import tmsf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int INDEX  = 0,
  localparam int AGE_W = $clog2(WINDOW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tmsf_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] left_value,
  input  logic [AGE_W-1:0]           left_age,
  input  logic signed [SAMPLE_W-1:0] right_value,
  input  logic [AGE_W-1:0]           right_age,
  output logic signed [SAMPLE_W-1:0] value,
  output logic [AGE_W-1:0]           age
);

  localparam bit HAS_L   = (INDEX > 0);
  localparam bit HAS_R   = (INDEX < WINDOW - 1);
  localparam bit IDX_ODD = ((INDEX % 2) == 1);

  logic signed [SAMPLE_W-1:0] value_next;
  logic [AGE_W-1:0]           age_next;
  logic                       is_left;

  // Pick this cell's role in the current compare-exchange pass
  assign is_left = (IDX_ODD == ctrl.odd);

  // Work out the next value and age
  always_comb begin
    value_next = value;
    age_next   = age;
    case (ctrl.op)
      OP_FILL: begin
        value_next = ctrl.x;
      end
      OP_REPLACE: begin
        if (age == AGE_W'(WINDOW - 1)) begin
          value_next = ctrl.x;
          age_next   = '0;
        end else begin
          age_next = age + AGE_W'(1);
        end
      end
      OP_SORT: begin
        if (is_left) begin
          if (HAS_R && (value > right_value)) begin
            value_next = right_value;
            age_next   = right_age;
          end
        end else begin
          if (HAS_L && (left_value > value)) begin
            value_next = left_value;
            age_next   = left_age;
          end
        end
      end
      OP_ROTATE: begin
        value_next = right_value;
        age_next   = right_age;
      end
      default: begin
      end
    endcase
  end

  // Hold the cell contents
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= AGE_W'(WINDOW - 1 - INDEX);
    end else begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

>>> hdl/tmsf_div.sv
module tmsf_div import tmsf_pkg::*; #(
  parameter int MAG_W = 19,
  parameter int KEEP  = KEEP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  output logic             done,
  output logic [MAG_W-1:0] quotient
);

  // Reciprocal of KEEP rounded up, scaled so that every MAG_W-bit word divides exactly
  localparam int     SHIFT   = MAG_W + $clog2(KEEP);
  localparam int     RECIP_W = MAG_W + 2;
  localparam int     PROD_W  = SHIFT + MAG_W;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(KEEP) - 1) / longint'(KEEP);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [PROD_W-1:0] product;

  // Multiply by the reciprocal; the quotient sits above the scaling bits
  assign product = PROD_W'(mag) * PROD_W'(RECIP);

  // Flag the quotient in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Capture the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= product[PROD_W-1:SHIFT];
    end
  end

  a_done_next: assert property (@(posedge clk) disable iff (rst) start |=> done)
    else $error("division did not finish one cycle after start");
  a_done_cause: assert property (@(posedge clk) disable iff (rst) done |-> $past(start))
    else $error("division done without a start");
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (quotient <= $past(mag)))
    else $error("quotient larger than the dividend");

endmodule

>>> hdl/trimmed_mean_step_filter.sv
// Channel   Direction  Handshake                 Word
// sample    in         sample_valid/sample_stall sample
// result    out        result_valid/result_stall filtered, jump_taken
// cfg       in         cfg_valid/cfg_ready       cfg_data (jump_gap)
//
// A jump goes straight to S_DONE and loads the output register from there.
// Any other word passes through these steps to the output register: WINDOW
// passes of odd-even exchange along the cell row, WINDOW rotation steps that
// feed the accumulator, the multiply by the reciprocal of KEEP and the load
// of the output register.
// rst is synchronous: the window reads all zero, jump_gap returns to 0.150.
// sample_stall is high while a word is in work; a finished result waits in
// res_value until the output register is free, so result_stall delays the next acceptance.
module trimmed_mean_step_filter import tmsf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int KEEP   = KEEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       jump_taken,
  output logic                       result_valid,
  input  logic                       result_stall,
  input  logic [GAP_W-1:0]           cfg_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready
);

  localparam int AGE_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + $clog2(KEEP + 1);
  localparam int MAG_W  = SUM_W - 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int HI     = TRIM_LOW + KEEP - 1;
  localparam int LO_END = (TRIM_LOW > WINDOW - 1) ? TRIM_LOW : WINDOW - 1;
  localparam int WLAST  = (HI >= WINDOW - 1) ? (HI - LO_END + 1) : 0;
  localparam logic signed [SUM_W-1:0] WLAST_S = SUM_W'(WLAST);

  tmsf_state_t state, state_next;
  tmsf_ctrl_t  ctrl;

  logic [CNT_W-1:0]           cnt;
  logic [GAP_W-1:0]           gap;
  logic signed [SAMPLE_W-1:0] newest;
  logic signed [SAMPLE_W-1:0] second;
  logic signed [SUM_W-1:0]    acc;
  logic                       neg;
  logic signed [SAMPLE_W-1:0] res_value;
  logic                       res_jump;

  logic signed [SAMPLE_W-1:0] cell_value [WINDOW];
  logic [AGE_W-1:0]           cell_age   [WINDOW];

  logic                       accept;
  logic                       jump;
  logic                       cnt_last;
  logic                       div_start;
  logic                       div_done;
  logic                       out_load;
  logic [MAG_W-1:0]           quotient;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   mag;
  logic signed [DIFF_W-1:0]   step_prev;
  logic signed [DIFF_W-1:0]   gap_e;
  logic signed [SUM_W-1:0]    head_e;
  logic signed [SUM_W-1:0]    term;
  logic signed [SUM_W-1:0]    sum_final;
  logic [SUM_W-1:0]           mag_bits;
  logic [SUM_W-1:0]           div_word;

  logic [WINDOW-1:0]          oldest_hit;
  logic [WINDOW-2:0]          pair_ok;

  // Row of sorting cells, closed into a ring for rotation
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int LI = (i + WINDOW - 1) % WINDOW;
    localparam int RI = (i + 1) % WINDOW;

    tmsf_cell #(
      .WINDOW (WINDOW),
      .INDEX  (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_value  (cell_value[LI]),
      .left_age    (cell_age[LI]),
      .right_value (cell_value[RI]),
      .right_age   (cell_age[RI]),
      .value       (cell_value[i]),
      .age         (cell_age[i])
    );

    assign oldest_hit[i] = (cell_age[i] == AGE_W'(WINDOW - 1));
  end

  for (genvar i = 0; i < WINDOW - 1; i++) begin : g_pair
    assign pair_ok[i] = (cell_value[i] <= cell_value[i + 1]);
  end

  // Jump test against the two newest samples
  assign gap_e     = $signed({2'b00, gap});
  assign diff      = DIFF_W'(sample) - DIFF_W'(newest);
  assign mag       = (diff < 0) ? -diff : diff;
  assign step_prev = (sample > newest) ? (DIFF_W'(newest) - DIFF_W'(second))
                                       : (DIFF_W'(second) - DIFF_W'(newest));
  assign jump      = (mag >= gap_e) && (step_prev >= gap_e);

  // Weighted term of the word at the head of the row
  assign head_e = SUM_W'(cell_value[0]);
  always_comb begin
    if (int'(cnt) == WINDOW - 1) begin
      term = head_e * WLAST_S;
    end else if ((int'(cnt) >= TRIM_LOW) && (int'(cnt) <= HI)) begin
      term = head_e;
    end else begin
      term = '0;
    end
  end

  // Split the final sum into sign and ones'-complement magnitude for the divider
  assign sum_final = acc + term;
  assign mag_bits  = sum_final[SUM_W-1] ? ~sum_final : sum_final;
  assign div_word  = neg ? ~{1'b0, quotient} : {1'b0, quotient};

  assign cnt_last     = (cnt == CNT_W'(WINDOW - 1));
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;

  tmsf_div #(
    .MAG_W (MAG_W),
    .KEEP  (KEEP)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (mag_bits[MAG_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell commands
  always_comb begin
    state_next = state;
    ctrl.op    = OP_HOLD;
    ctrl.odd   = cnt[0];
    ctrl.x     = sample;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (jump) begin
            ctrl.op    = OP_FILL;
            state_next = S_DONE;
          end else begin
            ctrl.op    = OP_REPLACE;
            state_next = S_SORT;
          end
        end
      end
      S_SORT: begin
        ctrl.op = OP_SORT;
        if (cnt_last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ctrl.op = OP_ROTATE;
        if (cnt_last) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Step counter for passes and rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else if (state == S_SORT || state == S_SUM) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Hold the register and the two newest samples
  always_ff @(posedge clk) begin
    if (rst) begin
      gap    <= GAP_RESET;
      newest <= '0;
      second <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap <= cfg_data;
      end
      if (accept) begin
        newest <= sample;
        second <= jump ? sample : newest;
      end
    end
  end

  // Accumulate the kept ranks and capture the pending result
  always_ff @(posedge clk) begin
    if (state == S_SORT) begin
      acc <= '0;
    end else if (state == S_SUM) begin
      acc <= sum_final;
    end
    if (div_start) begin
      neg <= sum_final[SUM_W-1];
    end
    if (accept && jump) begin
      res_value <= sample;
      res_jump  <= 1'b1;
    end else if (state == S_DIV && div_done) begin
      res_value <= div_word[SAMPLE_W-1:0];
      res_jump  <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered   <= res_value;
      jump_taken <= res_jump;
    end
  end

  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> $onehot(oldest_hit))
    else $error("cell ages do not mark exactly one oldest word");
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT && cnt_last) |=> (&pair_ok))
    else $error("cell row not in order after the last pass");
  a_jump_path: assert property (@(posedge clk) disable iff (rst)
    (accept && jump) |=> (state == S_DONE && res_jump))
    else $error("jump word did not go straight to the output stage");

endmodule

>>> tb/trimmed_mean_step_filter_tb.sv
module trimmed_mean_step_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmsf_pkg::*;

  localparam int WINDOW      = WINDOW_DEF;
  localparam int KEEP        = KEEP_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 229;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 100;
  localparam int DIR_ROWS    = 23;

  typedef enum bit {ROW_SAMPLE, ROW_GAP} dir_kind_t;

  // One line of the directed table: a sample word or a jump_gap write
  typedef struct {
    dir_kind_t kind;
    int        arg;
    bit        typed;
    int        exp_mean;
    bit        exp_jump;
  } dir_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mean;
    logic                       jump;
  } mean_word_t;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic signed [SAMPLE_W-1:0] sample       = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       jump_taken;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [GAP_W-1:0]           cfg_data     = '0;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;

  // Window image kept alongside the block
  longint     win_val [WINDOW];
  int         next_slot;
  longint     gap_model;
  mean_word_t pending_means [$];

  int     mismatches = 0;
  int     words_seen = 0;
  bit     calm       = 1'b0;
  int     hold_asks  = 0;
  longint walk_last  = 0;
  longint walk_dir   = 1;

  // Directed words from reset; typed rows carry their expected word
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_SAMPLE,       0, 1'b1,       0, 1'b0},
    '{ROW_SAMPLE,  131071, 1'b1,       0, 1'b0},
    '{ROW_SAMPLE, -131072, 1'b1,       0, 1'b0},
    '{ROW_SAMPLE, -131072, 1'b1,  -65536, 1'b0},
    '{ROW_SAMPLE,  131071, 1'b1,      -1, 1'b0},
    '{ROW_SAMPLE,       0, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,       0, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,     200, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,     400, 1'b1,     400, 1'b1},
    '{ROW_SAMPLE,     400, 1'b1,     400, 1'b0},
    '{ROW_SAMPLE,     200, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,       0, 1'b1,       0, 1'b1},
    '{ROW_GAP,          0, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,       0, 1'b1,       0, 1'b1},
    '{ROW_SAMPLE,      -5, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,       7, 1'b0,       0, 1'b0},
    '{ROW_GAP,     131071, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,  131071, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE, -131072, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,       0, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,  131071, 1'b1,  131071, 1'b1},
    '{ROW_GAP,        150, 1'b0,       0, 1'b0},
    '{ROW_SAMPLE,      -1, 1'b0,       0, 1'b0}
  };

  trimmed_mean_step_filter #(
    .WINDOW(WINDOW),
    .KEEP  (KEEP)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .filtered    (filtered),
    .jump_taken  (jump_taken),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cfg_data    (cfg_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch at word %0d: %s", words_seen, msg);
    mismatches++;
  endtask

  // Advance the window by one sample and work out the word it yields
  task automatic advance_window(input logic signed [SAMPLE_W-1:0] x_in,
                                output logic signed [SAMPLE_W-1:0] mean_out,
                                output logic jump_out);
    longint x, newest, second, mag, sum, m, tmp;
    longint ranked [WINDOW];
    int     cur, i, j, r;
    logic   jump;
    x      = x_in;
    cur    = next_slot;
    newest = win_val[(cur + WINDOW - 1) % WINDOW];
    second = win_val[(cur + WINDOW - 2) % WINDOW];
    mag    = (x < newest) ? newest - x : x - newest;
    jump   = 1'b0;
    // a zero difference counts as a non-rising step
    if (mag >= gap_model) begin
      if (x > newest) jump = (newest - second) >= gap_model;
      else jump = (second - newest) >= gap_model;
    end
    if (jump) begin
      // refill every slot, oldest pointer stays put
      for (i = 0; i < WINDOW; i++) win_val[i] = x;
      m = x;
    end else begin
      win_val[cur] = x;
      next_slot = (cur + 1) % WINDOW;
      for (i = 0; i < WINDOW; i++) ranked[i] = win_val[i];
      for (i = 1; i < WINDOW; i++) begin
        tmp = ranked[i];
        j = i - 1;
        while (j >= 0 && ranked[j] > tmp) begin
          ranked[j + 1] = ranked[j];
          j--;
        end
        ranked[j + 1] = tmp;
      end
      sum = 0;
      for (i = 0; i < KEEP; i++) begin
        r = TRIM_LOW + i;
        if (r > WINDOW - 1) r = WINDOW - 1;
        sum += ranked[r];
      end
      // floor division toward minus infinity
      if (sum >= 0) m = sum / KEEP;
      else m = -((-sum + KEEP - 1) / KEEP);
    end
    mean_out = m[SAMPLE_W-1:0];
    jump_out = jump;
  endtask

  // Random walk around the gap so that two-step jumps come up often
  function automatic longint next_sample(input longint g);
    longint v, step;
    int     pick;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0) walk_dir = -walk_dir;
    if (pick < 55) begin
      step = g + longint'($urandom_range(8)) - 4;
      if (step < 0) step = 0;
      v = walk_last + walk_dir * step;
    end else if (pick < 75) begin
      v = walk_last + longint'($urandom_range(g + 4)) - (g / 2 + 2);
    end else if (pick < 92) begin
      v = longint'($urandom_range(262143)) - 131072;
    end else begin
      case ($urandom_range(3))
        0:       v = -131072;
        1:       v = 131071;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    if (v > 131071) begin
      v = 131071;
      walk_dir = -1;
    end else if (v < -131072) begin
      v = -131072;
      walk_dir = 1;
    end
    walk_last = v;
    return v;
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, input bit typed,
                              input int exp_mean, input bit exp_jump);
    mean_word_t want;
    while (!calm && $urandom_range(99) < 20) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= v;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    advance_window(v, want.mean, want.jump);
    if (typed) begin
      want.mean = SAMPLE_W'(exp_mean);
      want.jump = exp_jump;
    end
    pending_means.push_back(want);
  endtask

  // Stop offering and let every outstanding word come back
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] g);
    wait_drained();
    cfg_data  <= g;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gap_model = g;
  endtask

  // Result side: check each accepted word, then pick the next stall
  initial begin : result_side
    mean_word_t want;
    int         hold_left;
    int         hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        words_seen++;
        if (pending_means.size() == 0) begin
          log_mismatch($sformatf("unexpected word filtered=%0d jump_taken=%0b",
                                 filtered, jump_taken));
        end else begin
          want = pending_means.pop_front();
          if (filtered !== want.mean)
            log_mismatch($sformatf("filtered %0d, expected %0d", filtered, want.mean));
          if (jump_taken !== want.jump)
            log_mismatch($sformatf("jump_taken %0b, expected %0b", jump_taken, want.jump));
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        result_stall <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int         i, phase, n;
    logic [GAP_W-1:0] g;
    for (i = 0; i < WINDOW; i++) win_val[i] = 0;
    next_slot = 0;
    gap_model = GAP_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed walk
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_GAP)
        write_gap(GAP_W'(dir_table[i].arg));
      else
        offer_sample(SAMPLE_W'(dir_table[i].arg), dir_table[i].typed,
                     dir_table[i].exp_mean, dir_table[i].exp_jump);
    end

    // Random phases, each under its own jump_gap
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       g = 17'd150;
        1:       g = 17'd0;
        2:       g = 17'd1;
        3:       g = 17'd131071;
        4:       g = GAP_W'($urandom_range(2, 3000));
        5:       g = GAP_W'($urandom_range(131071));
        6:       g = 17'd65535;
        default: g = GAP_RESET;
      endcase
      write_gap(g);
      calm <= (phase == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 100) hold_asks <= hold_asks + 1;
        if (phase == 2 && n == 120) wait_drained();
        offer_sample(SAMPLE_W'(next_sample(gap_model)), 1'b0, 0, 1'b0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tmsf_pkg.sv
hdl/tmsf_cell.sv
hdl/tmsf_div.sv
hdl/trimmed_mean_step_filter.sv
tb/trimmed_mean_step_filter_tb.sv
